// ----- rtl/core/epsm_pkg.sv -----
// Shared types, codes and constants of the edge period speed meter.
package epsm_pkg;

    // Edge level codes.
    localparam logic [1:0] LVL_FALL    = 2'd0;
    localparam logic [1:0] LVL_RISE    = 2'd1;
    localparam logic [1:0] LVL_TIMEOUT = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_OLD_WEIGHT = 2'd0;
    localparam logic [1:0] REG_TICK_RATE  = 2'd1;
    localparam logic [1:0] REG_PULSES_REV = 2'd2;

    // Field widths.
    localparam int WEIGHT_W = 17;
    localparam int RATE_W   = 27;
    localparam int PPR_W    = 16;
    localparam int STAMP_W  = 32;
    localparam int FREQ_W   = 35;
    localparam int RPM_W    = 41;
    localparam int CFG_W    = 27;
    localparam int PROD_W   = WEIGHT_W + STAMP_W;

    // Reset values of the configuration registers.
    localparam logic [WEIGHT_W-1:0] ONE_Q16          = 17'd65536;
    localparam logic [WEIGHT_W-1:0] RST_OLD_WEIGHT   = 17'd6554;
    localparam logic [RATE_W-1:0]   RST_TICK_RATE    = 27'd1000000;
    localparam logic [PPR_W-1:0]    RST_PULSES_REV   = 16'd90;

    // Shared divider geometry: dividend up to 60 * rate * 256, divisor up to period * ppr.
    localparam int DVD_W = 41;
    localparam int DSR_W = 48;
    localparam int CNT_W = 6;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DSR_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quotient;
    } t_div_rsp;

endpackage

// ----- rtl/core/edge_period_speed_meter_core.sv -----
// Top level of the edge period speed meter: sequencer, shared multiplier and divider.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-----------------------------------------
//  edge in | in        | i_in_valid / o_in_stall   | i_edge_level, i_stamp
//  result  | out       | o_out_valid / i_out_stall | o_pulse, o_period_ticks, o_freq_q8, o_rpm_q8
//  config  | in        | i_cfg_wr_en               | i_cfg_idx, i_cfg_wr_data
//
// An item with a period runs through these steps from accept to result: the
// period is measured, then blended when a period is already held, then
// period * pulses_per_rev is formed, then two passes go through the shared
// restoring divider (a quotient step per dividend bit and a done strobe;
// frequency, then rpm), and at last the result register is loaded. A zero
// pulses_per_rev skips the rpm pass; a zero period skips both divisions.
// The next item can be accepted in the cycle after the result register is loaded.
// Synchronous active-low reset clears the state and the output valid flag and
// loads the configuration defaults. The input side stalls for the whole
// computation; the result register holds a finished item while the output
// side stalls, and a new item is accepted meanwhile.
module edge_period_speed_meter_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,

    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [1:0]                     i_edge_level,
    input  logic [epsm_pkg::STAMP_W-1:0]   i_stamp,

    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_pulse,
    output logic [epsm_pkg::STAMP_W-1:0]   o_period_ticks,
    output logic [epsm_pkg::FREQ_W-1:0]    o_freq_q8,
    output logic [epsm_pkg::RPM_W-1:0]     o_rpm_q8,

    input  logic                           i_cfg_wr_en,
    input  logic [1:0]                     i_cfg_idx,
    input  logic [epsm_pkg::CFG_W-1:0]     i_cfg_wr_data
);
    import epsm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPD,
        S_BLEND,
        S_PREP,
        S_FDIV,
        S_RDIV,
        S_DONE
    } t_state;

    t_state r_state;

    // Configuration.
    logic [WEIGHT_W-1:0] r_weight;
    logic [RATE_W-1:0]   r_rate;
    logic [PPR_W-1:0]    r_ppr;

    // Measurement state.
    logic [STAMP_W-1:0]  r_last;
    logic [STAMP_W-1:0]  r_period;

    // Per-item working registers.
    logic [1:0]          r_level;
    logic [STAMP_W-1:0]  r_stamp;
    logic [STAMP_W-1:0]  r_d;
    logic [PROD_W-1:0]   r_acc;
    logic [DSR_W-1:0]    r_den;
    logic                r_pulse;
    logic [FREQ_W-1:0]   r_freq;
    logic [RPM_W-1:0]    r_rpm;

    // Output register.
    logic                r_out_valid;
    logic                r_out_pulse;
    logic [STAMP_W-1:0]  r_out_period;
    logic [FREQ_W-1:0]   r_out_freq;
    logic [RPM_W-1:0]    r_out_rpm;

    logic                in_acc;
    logic                out_free;
    logic [WEIGHT_W-1:0] mul_a;
    logic [STAMP_W-1:0]  mul_b;
    logic [PROD_W-1:0]   prod;
    logic [PROD_W-1:0]   blend_sum;
    logic [STAMP_W-1:0]  diff;
    logic [DVD_W-1:0]    freq_dvd;
    logic [DVD_W-1:0]    rpm_dvd;
    logic [WEIGHT_W-1:0] cfg_weight;
    t_div_req            div_req;
    t_div_rsp            div_rsp;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;

    // Wrapping tick difference to the last rising edge.
    assign diff = r_stamp - r_last;

    // One 17x32 multiplier serves the old-weight term, the new-weight term
    // and period * pulses_per_rev, in that order.
    always_comb begin
        unique case (r_state)
            S_UPD: begin
                mul_a = r_weight;
                mul_b = r_period;
            end
            S_BLEND: begin
                mul_a = ONE_Q16 - r_weight;
                mul_b = r_d;
            end
            default: begin
                mul_a = {1'b0, r_ppr};
                mul_b = r_period;
            end
        endcase
    end

    assign prod      = {{STAMP_W{1'b0}}, mul_a} * {{WEIGHT_W{1'b0}}, mul_b};
    assign blend_sum = r_acc + prod;

    // rate * 256 and rate * 256 * 60, the latter as (x << 6) - (x << 2).
    assign freq_dvd = {6'b0, r_rate, 8'b0};
    assign rpm_dvd  = {r_rate, 14'b0} - {4'b0, r_rate, 10'b0};

    // Saturate the old weight at one.
    assign cfg_weight = (i_cfg_wr_data[WEIGHT_W-1:0] > ONE_Q16) ?
                        ONE_Q16 : i_cfg_wr_data[WEIGHT_W-1:0];

    // Launch the frequency division after the period settles, then the rpm
    // division once the frequency quotient is in.
    always_comb begin
        div_req.start    = 1'b0;
        div_req.dividend = freq_dvd;
        div_req.divisor  = {16'b0, r_period};
        if (r_state == S_PREP && r_period != '0) begin
            div_req.start = 1'b1;
        end else if (r_state == S_FDIV) begin
            div_req.dividend = rpm_dvd;
            div_req.divisor  = r_den;
            div_req.start    = div_rsp.done && (r_ppr != '0);
        end
    end

    epsm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight <= RST_OLD_WEIGHT;
            r_rate   <= RST_TICK_RATE;
            r_ppr    <= RST_PULSES_REV;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_idx)
                REG_OLD_WEIGHT: r_weight <= cfg_weight;
                REG_TICK_RATE:  r_rate   <= i_cfg_wr_data[RATE_W-1:0];
                REG_PULSES_REV: r_ppr    <= i_cfg_wr_data[PPR_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer, measurement state and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_last      <= '0;
            r_period    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // Drop the result once taken, unless a new one loads this cycle.
            if (r_out_valid && !i_out_stall && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_level <= i_edge_level;
                        r_stamp <= i_stamp;
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    r_freq <= '0;
                    r_rpm  <= '0;
                    // A stored stamp of zero means no rising edge yet.
                    if (r_level == LVL_RISE && r_last != '0 && r_period != '0) begin
                        r_acc   <= prod;
                        r_d     <= diff;
                        r_pulse <= 1'b1;
                        r_state <= S_BLEND;
                    end else begin
                        r_pulse <= 1'b0;
                        r_state <= S_PREP;
                        if (r_level == LVL_RISE && r_last != '0) begin
                            r_period <= diff;
                        end
                    end
                    if (r_level == LVL_RISE) begin
                        r_last <= r_stamp;
                    end
                end
                S_BLEND: begin
                    // Truncate the Q16 blend to whole ticks.
                    r_period <= blend_sum[STAMP_W+15:16];
                    r_state  <= S_PREP;
                end
                S_PREP: begin
                    r_den   <= prod[DSR_W-1:0];
                    r_state <= (r_period != '0) ? S_FDIV : S_DONE;
                end
                S_FDIV: begin
                    if (div_rsp.done) begin
                        r_freq  <= div_rsp.quotient[FREQ_W-1:0];
                        r_state <= (r_ppr != '0) ? S_RDIV : S_DONE;
                    end
                end
                S_RDIV: begin
                    if (div_rsp.done) begin
                        r_rpm   <= div_rsp.quotient;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    // Hold until the output register is free.
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_pulse  <= r_pulse;
                        r_out_period <= r_period;
                        r_out_freq   <= r_freq;
                        r_out_rpm    <= r_rpm;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_pulse        = r_out_pulse;
    assign o_period_ticks = r_out_period;
    assign o_freq_q8      = r_out_freq;
    assign o_rpm_q8       = r_out_rpm;

    a_weight_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_weight <= ONE_Q16)
        else $error("old weight above one");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_FDIV || r_state == S_RDIV))
        else $error("divider finished outside a division step");

    a_zero_period: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_period_ticks == '0) |-> (o_freq_q8 == '0 && o_rpm_q8 == '0))
        else $error("speed reported without a period");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_UPD))
        else $error("accepted item not taken into the sequencer");

endmodule

// ----- rtl/core/epsm_div.sv -----
// Restoring radix-2 divider, one quotient bit per cycle.
module epsm_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  epsm_pkg::t_div_req i_req,
    output epsm_pkg::t_div_rsp o_rsp
);
    import epsm_pkg::*;

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DVD_W-1:0] r_qd;
    logic [DSR_W-1:0] r_rem;
    logic [DSR_W-1:0] r_dsr;

    logic [DSR_W:0]   rem_sh;
    logic [DSR_W+1:0] trial;
    logic             ge;

    // Shift in the next dividend bit, try a subtract.
    assign rem_sh = {r_rem, r_qd[DVD_W-1]};
    assign trial  = {1'b0, rem_sh} - {2'b00, r_dsr};
    assign ge     = ~trial[DSR_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DVD_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_qd  <= i_req.dividend;
            r_rem <= '0;
            r_dsr <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= ge ? trial[DSR_W-1:0] : rem_sh[DSR_W-1:0];
            r_qd  <= {r_qd[DVD_W-2:0], ge};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_qd;

endmodule
